// ===== src/pbq_pkg.sv =====
package pbq_pkg;

  // Number of quotient bits produced by each of the two divisions.
  localparam int DIV_STEPS = 8;

  localparam logic [63:0] COLOR_RESET = 64'h8080_8080_8080_8080;

  // Configuration register indexes (byte address divided by eight).
  localparam logic [2:0] REG_START_COLORS     = 3'd0;
  localparam logic [2:0] REG_MID_COLORS       = 3'd1;
  localparam logic [2:0] REG_END_COLORS       = 3'd2;
  localparam logic [2:0] REG_MID_POINT        = 3'd3;
  localparam logic [2:0] REG_RIGHT_VECTOR     = 3'd4;
  localparam logic [2:0] REG_UP_VECTOR        = 3'd5;
  localparam logic [2:0] REG_EMITTER_POSITION = 3'd6;

  // Vertex order within one quad.
  localparam logic [2:0] VTX_CENTER       = 3'd0;
  localparam logic [2:0] VTX_TOP_LEFT     = 3'd1;
  localparam logic [2:0] VTX_TOP_RIGHT    = 3'd2;
  localparam logic [2:0] VTX_BOTTOM_RIGHT = 3'd3;
  localparam logic [2:0] VTX_BOTTOM_LEFT  = 3'd4;

  // Which two color registers a particle blends between.
  typedef enum logic [1:0] {
    PAIR_START_END,
    PAIR_START_MID,
    PAIR_MID_END
  } pair_t;

  typedef struct packed {
    logic [15:0]        age;
    logic [15:0]        life;
    logic [15:0]        start_width;
    logic [15:0]        end_width;
    logic [15:0]        start_height;
    logic [15:0]        end_height;
    logic signed [19:0] offset_x;
    logic signed [19:0] offset_y;
    logic signed [19:0] offset_z;
  } particle_t;

  typedef struct packed {
    logic [2:0]         vertex_index;
    logic signed [19:0] vertex_x;
    logic signed [19:0] vertex_y;
    logic signed [19:0] vertex_z;
    logic [31:0]        color_first;
    logic [31:0]        color_second;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [63:0]       start_colors;
    logic [63:0]       mid_colors;
    logic [63:0]       end_colors;
    logic signed [8:0] mid_point;
    logic [47:0]       right_vector;
    logic [47:0]       up_vector;
    logic [59:0]       emitter_position;
  } cfg_t;

  // One classified particle as it waits between the two halves.
  typedef struct packed {
    logic [8:0]         t;
    logic [8:0]         f;
    pair_t              pair;
    logic [15:0]        start_width;
    logic [15:0]        end_width;
    logic [15:0]        start_height;
    logic [15:0]        end_height;
    logic signed [19:0] offset_x;
    logic signed [19:0] offset_y;
    logic signed [19:0] offset_z;
  } work_t;

endpackage

// ===== src/pbq_front.sv =====
module pbq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              particle_valid,
  output logic              particle_stall,
  input  pbq_pkg::particle_t particle,
  input  logic signed [8:0] mid_point,
  output logic              push,
  output pbq_pkg::work_t    push_data,
  input  logic              full
);
  import pbq_pkg::*;

  localparam int STAGES      = 2 * DIV_STEPS + 2;
  localparam int SETUP_STAGE = DIV_STEPS + 1;

  typedef struct packed {
    particle_t   p;
    logic        sat;
    logic [16:0] rem;
    logic [15:0] dv;
    logic [7:0]  q;
    logic [8:0]  t;
    pair_t       pair;
  } stage_t;

  stage_t              stg [STAGES];
  logic [STAGES-1:0]   vld;
  logic                advance;

  function automatic stage_t load_stage(input particle_t p);
    stage_t o;
    o      = '0;
    o.p    = p;
    o.sat  = (p.age >= p.life);
    o.rem  = {1'b0, p.age};
    o.dv   = p.life;
    o.pair = PAIR_START_END;
    return o;
  endfunction

  // One restoring division step; the dividend's low bits are all zero.
  function automatic stage_t div_step(input stage_t s);
    stage_t      o;
    logic [16:0] r2;
    o  = s;
    r2 = {s.rem[15:0], 1'b0};
    if (r2 >= {1'b0, s.dv}) begin
      o.rem = r2 - {1'b0, s.dv};
      o.q   = {s.q[6:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {s.q[6:0], 1'b0};
    end
    return o;
  endfunction

  // Latch t, choose the color pair and set up the color factor division.
  function automatic stage_t f_setup(input stage_t s, input logic signed [8:0] m);
    stage_t     o;
    logic [8:0] tv;
    logic [8:0] mu;
    logic [8:0] n;
    logic [8:0] d;
    o  = s;
    tv = s.sat ? 9'd256 : {1'b0, s.q};
    mu = {1'b0, m[7:0]};
    if (m[8]) begin
      o.pair = PAIR_START_END;
      n      = tv;
      d      = 9'd256;
    end else if (tv < mu) begin
      o.pair = PAIR_START_MID;
      n      = tv;
      d      = mu;
    end else begin
      o.pair = PAIR_MID_END;
      n      = tv - mu;
      d      = 9'd256 - mu;
    end
    o.t   = tv;
    o.sat = (n >= d);
    o.rem = {8'd0, n};
    o.dv  = {7'd0, d};
    o.q   = '0;
    return o;
  endfunction

  assign advance        = !vld[STAGES-1] || !full;
  assign particle_stall = !advance;
  assign push           = vld[STAGES-1] && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[STAGES-2:0], particle_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg[0] <= load_stage(particle);
      for (int k = 1; k < STAGES; k++) begin
        if (k == SETUP_STAGE) begin
          stg[k] <= f_setup(stg[k-1], mid_point);
        end else begin
          stg[k] <= div_step(stg[k-1]);
        end
      end
    end
  end

  always_comb begin
    push_data.t            = stg[STAGES-1].t;
    push_data.f            = stg[STAGES-1].sat ? 9'd256 : {1'b0, stg[STAGES-1].q};
    push_data.pair         = stg[STAGES-1].pair;
    push_data.start_width  = stg[STAGES-1].p.start_width;
    push_data.end_width    = stg[STAGES-1].p.end_width;
    push_data.start_height = stg[STAGES-1].p.start_height;
    push_data.end_height   = stg[STAGES-1].p.end_height;
    push_data.offset_x     = stg[STAGES-1].p.offset_x;
    push_data.offset_y     = stg[STAGES-1].p.offset_y;
    push_data.offset_z     = stg[STAGES-1].p.offset_z;
  end

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    vld[STAGES-1] |-> (stg[STAGES-1].t <= 9'd256))
    else $error("normalized age out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGES-1] && full) |=> vld[STAGES-1] && $stable(stg[STAGES-1].t))
    else $error("front result changed while the queue was full");

  a_f_range: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.f <= 9'd256))
    else $error("color factor out of range");

endmodule

// ===== src/pbq_fifo.sv =====
module pbq_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbq_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output pbq_pkg::work_t head,
  output logic           empty
);
  import pbq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");

endmodule

// ===== src/pbq_back.sv =====
module pbq_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  output logic             pop,
  input  pbq_pkg::work_t   head,
  input  pbq_pkg::cfg_t    cfg,
  output logic             vertex_valid,
  input  logic             vertex_stall,
  output pbq_pkg::vertex_t vertex
);
  import pbq_pkg::*;

  // Stage 1: size and color products, center.
  logic               s1_valid;
  logic [15:0]        s1_sw;
  logic [15:0]        s1_sh;
  logic signed [26:0] s1_pw;
  logic signed [26:0] s1_ph;
  logic signed [19:0] s1_center [3];
  logic signed [17:0] s1_prod [8];
  logic [7:0]         s1_base [8];

  // Stage 2: sizes and final colors.
  logic               s2_valid;
  logic [15:0]        s2_w;
  logic [15:0]        s2_h;
  logic signed [19:0] s2_center [3];
  logic [63:0]        s2_color;

  // Vertex emitter.
  logic               e_valid;
  logic [2:0]         e_cnt;
  logic signed [19:0] e_center [3];
  logic signed [18:0] e_r [3];
  logic signed [18:0] e_u [3];
  logic [63:0]        e_color;

  logic               out_adv;
  logic               e_free;
  logic               be;

  logic signed [16:0] dw_c;
  logic signed [16:0] dh_c;
  logic signed [9:0]  tw_c;
  logic signed [9:0]  fw_c;
  logic signed [26:0] pw_c;
  logic signed [26:0] ph_c;
  logic [63:0]        ca;
  logic [63:0]        cb;
  logic signed [19:0] off_c [3];
  logic signed [19:0] em_c [3];
  logic signed [19:0] center_c [3];
  logic signed [17:0] prod_c [8];
  logic signed [26:0] wsum_c;
  logic signed [26:0] hsum_c;
  logic [63:0]        color_c;
  logic signed [18:0] r_c [3];
  logic signed [18:0] u_c [3];
  logic signed [19:0] pos_c [3];

  function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
    if (v > 22'sd524287) begin
      return 20'sd524287;
    end else if (v < -22'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  assign out_adv = !vertex_valid || !vertex_stall;
  assign e_free  = !e_valid || (out_adv && (e_cnt == VTX_BOTTOM_LEFT));
  assign be      = !s2_valid || e_free;
  assign pop     = !empty && be;

  always_comb begin
    dw_c     = $signed({1'b0, head.end_width}) - $signed({1'b0, head.start_width});
    dh_c     = $signed({1'b0, head.end_height}) - $signed({1'b0, head.start_height});
    tw_c     = $signed({1'b0, head.t});
    fw_c     = $signed({1'b0, head.f});
    pw_c     = dw_c * tw_c;
    ph_c     = dh_c * tw_c;
    off_c[0] = head.offset_x;
    off_c[1] = head.offset_y;
    off_c[2] = head.offset_z;
    for (int i = 0; i < 3; i++) begin
      em_c[i]     = $signed(cfg.emitter_position[20*i +: 20]);
      center_c[i] = sat20(22'(off_c[i]) + 22'(em_c[i]));
    end
    case (head.pair)
      PAIR_START_MID: begin
        ca = cfg.start_colors;
        cb = cfg.mid_colors;
      end
      PAIR_MID_END: begin
        ca = cfg.mid_colors;
        cb = cfg.end_colors;
      end
      default: begin
        ca = cfg.start_colors;
        cb = cfg.end_colors;
      end
    endcase
    for (int k = 0; k < 8; k++) begin
      prod_c[k] = ($signed({1'b0, cb[8*k +: 8]}) - $signed({1'b0, ca[8*k +: 8]})) * fw_c;
    end
  end

  always_comb begin
    logic signed [17:0] adj;
    logic signed [17:0] q;
    wsum_c  = $signed({11'd0, s1_sw}) + (s1_pw >>> 8);
    hsum_c  = $signed({11'd0, s1_sh}) + (s1_ph >>> 8);
    color_c = '0;
    for (int k = 0; k < 8; k++) begin
      // Truncate the scaled delta toward zero, then wrap.
      adj = s1_prod[k] + (s1_prod[k][17] ? 18'sd255 : 18'sd0);
      q   = adj >>> 8;
      color_c[8*k +: 8] = s1_base[k] + q[7:0];
    end
  end

  always_comb begin
    logic signed [32:0] rp;
    logic signed [32:0] up;
    for (int i = 0; i < 3; i++) begin
      rp     = $signed(cfg.right_vector[16*i +: 16]) * $signed({1'b0, s2_w});
      up     = $signed(cfg.up_vector[16*i +: 16]) * $signed({1'b0, s2_h});
      r_c[i] = rp[32:14];
      u_c[i] = up[32:14];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (e_cnt)
        VTX_TOP_LEFT:     pos_c[i] = sat20(22'(e_center[i]) - 22'(e_r[i]) + 22'(e_u[i]));
        VTX_TOP_RIGHT:    pos_c[i] = sat20(22'(e_center[i]) + 22'(e_r[i]) + 22'(e_u[i]));
        VTX_BOTTOM_RIGHT: pos_c[i] = sat20(22'(e_center[i]) + 22'(e_r[i]) - 22'(e_u[i]));
        VTX_BOTTOM_LEFT:  pos_c[i] = sat20(22'(e_center[i]) - 22'(e_r[i]) - 22'(e_u[i]));
        default:          pos_c[i] = e_center[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      e_valid      <= 1'b0;
      e_cnt        <= VTX_CENTER;
      vertex_valid <= 1'b0;
    end else begin
      if (be) begin
        s1_valid <= !empty;
        s2_valid <= s1_valid;
      end
      if (e_free) begin
        e_valid <= s2_valid;
        e_cnt   <= VTX_CENTER;
      end else if (e_valid && out_adv) begin
        e_cnt <= e_cnt + 1'b1;
      end
      if (out_adv) begin
        vertex_valid <= e_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      s1_sw <= head.start_width;
      s1_sh <= head.start_height;
      s1_pw <= pw_c;
      s1_ph <= ph_c;
      for (int i = 0; i < 3; i++) begin
        s1_center[i] <= center_c[i];
        s2_center[i] <= s1_center[i];
      end
      for (int k = 0; k < 8; k++) begin
        s1_prod[k] <= prod_c[k];
        s1_base[k] <= ca[8*k +: 8];
      end
      s2_w     <= wsum_c[15:0];
      s2_h     <= hsum_c[15:0];
      s2_color <= color_c;
    end
    if (e_free) begin
      for (int i = 0; i < 3; i++) begin
        e_center[i] <= s2_center[i];
        e_r[i]      <= r_c[i];
        e_u[i]      <= u_c[i];
      end
      e_color <= s2_color;
    end
    if (out_adv) begin
      vertex.vertex_index <= e_cnt;
      vertex.vertex_x     <= pos_c[0];
      vertex.vertex_y     <= pos_c[1];
      vertex.vertex_z     <= pos_c[2];
      vertex.color_first  <= e_color[31:0];
      vertex.color_second <= e_color[63:32];
      vertex.last_vertex  <= (e_cnt == VTX_BOTTOM_LEFT);
    end
  end

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> (vertex.last_vertex == (vertex.vertex_index == VTX_BOTTOM_LEFT)))
    else $error("last flag does not match vertex index");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    e_valid |-> (e_cnt <= VTX_BOTTOM_LEFT))
    else $error("vertex counter out of range");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (e_free && s2_valid) |=> (e_valid && (e_cnt == VTX_CENTER)))
    else $error("emitter did not start a new quad at the center");

endmodule

// ===== src/particle_billboard_quad_gen.sv =====
// Billboard particle quad generator.
// Each word on the particle channel describes one particle: its age and life,
// its half size at birth and at death, and its offset from the emitter. For
// every particle the block returns five words on the vertex channel: the
// center, then the top-left, top-right, bottom-right and bottom-left corners
// of a quad spanned by the right and up vectors. Each vertex word carries the
// two RGBA colors of the particle, blended along its life, and the final one
// has last_vertex set.
// Both channels move a word at a clock edge where valid is high and stall is
// low. The vertex channel delivers one word per cycle while vertex_stall is
// low; the emitter's five words per particle set the particle rate.
// From an accepted particle to its center vertex the path runs through
// an 18-stage divider pipeline for the age fraction and the color factor, the
// queue, two arithmetic stages, the emitter and the output register.
// When the receiver stalls, the output word holds, the emitter and the back
// stages fill, the queue absorbs up to QUEUE_DEPTH particles and then the
// divider pipeline stops and stall is raised on the particle channel.
// Reset empties every stage and the queue and loads the register defaults.
// Registers sit on the APB port at byte address 8 times their index. The user
// must write them only while the block is idle; the block does not enforce it.
module particle_billboard_quad_gen #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               particle_valid,
  output logic               particle_stall,
  input  pbq_pkg::particle_t particle,
  output logic               vertex_valid,
  input  logic               vertex_stall,
  output pbq_pkg::vertex_t   vertex,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import pbq_pkg::*;

  cfg_t  cfg;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  work_t push_data;
  work_t head;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register file. Writes to the unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_colors     <= COLOR_RESET;
      cfg.mid_colors       <= COLOR_RESET;
      cfg.end_colors       <= COLOR_RESET;
      cfg.mid_point        <= -9'sd1;
      cfg.right_vector     <= '0;
      cfg.up_vector        <= '0;
      cfg.emitter_position <= '0;
    end else if (wr_en) begin
      case (paddr[5:3])
        REG_START_COLORS:     cfg.start_colors     <= pwdata;
        REG_MID_COLORS:       cfg.mid_colors       <= pwdata;
        REG_END_COLORS:       cfg.end_colors       <= pwdata;
        REG_MID_POINT:        cfg.mid_point        <= $signed(pwdata[8:0]);
        REG_RIGHT_VECTOR:     cfg.right_vector     <= pwdata[47:0];
        REG_UP_VECTOR:        cfg.up_vector        <= pwdata[47:0];
        REG_EMITTER_POSITION: cfg.emitter_position <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  // The mid point reads back sign extended.
  always_comb begin
    case (paddr[5:3])
      REG_START_COLORS:     prdata = cfg.start_colors;
      REG_MID_COLORS:       prdata = cfg.mid_colors;
      REG_END_COLORS:       prdata = cfg.end_colors;
      REG_MID_POINT:        prdata = 64'(cfg.mid_point);
      REG_RIGHT_VECTOR:     prdata = {16'd0, cfg.right_vector};
      REG_UP_VECTOR:        prdata = {16'd0, cfg.up_vector};
      REG_EMITTER_POSITION: prdata = {4'd0, cfg.emitter_position};
      default:              prdata = '0;
    endcase
  end

  // Front: age fraction, color pair choice and color factor.
  pbq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .particle_valid (particle_valid),
    .particle_stall (particle_stall),
    .particle       (particle),
    .mid_point      (cfg.mid_point),
    .push           (push),
    .push_data      (push_data),
    .full           (full)
  );

  // Queue between the two halves so each can stall on its own.
  pbq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // Back: sizes, colors, corner offsets and the five-vertex emitter.
  pbq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop          (pop),
    .head         (head),
    .cfg          (cfg),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pbq_pkg::*;

  logic       clk;
  logic       rst;
  logic       particle_valid;
  logic       particle_stall;
  particle_t  particle;
  logic       vertex_valid;
  logic       vertex_stall;
  vertex_t    vertex;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic       pready;

  particle_billboard_quad_gen dut (
    .clk(clk), .rst(rst),
    .particle_valid(particle_valid), .particle_stall(particle_stall), .particle(particle),
    .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The testbench keeps its own copy of the register file. It is updated
  // when a write is issued, which is safe because writes only happen while
  // the block is idle.
  cfg_t shadow_cfg;

  particle_t pending_particles[$];
  vertex_t   expected_vertices[$];

  int  fail_count;
  int  cycle_count;
  int  send_idle_pct;
  int  stall_pct;
  bit  hold_sender;

  localparam int CYCLE_LIMIT = 400000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A cycle counter guards against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic signed [19:0] sat_coord(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  // Arithmetic shift right equals floor division by a power of two.
  function automatic longint floor_div_pow2(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic [31:0] blend_color(logic [31:0] a, logic [31:0] b, longint f);
    logic [31:0] out;
    longint sa, sb, p, q;
    out = '0;
    for (int k = 0; k < 4; k++) begin
      sa = a[8*k +: 8];
      sb = b[8*k +: 8];
      p = (sb - sa) * f;
      q = (p >= 0) ? p / 256 : -((-p) / 256);
      out[8*k +: 8] = 8'(sa + q);
    end
    return out;
  endfunction

  // Computes the five vertex words of one particle under the current
  // register settings and appends them to the expectation queue.
  task automatic predict_quad(particle_t p);
    longint t, w, h, f, m, quo;
    longint ctr[3], rv[3], uv[3], off[3], em[3];
    logic [63:0] ca, cb;
    logic [31:0] col0, col1;
    vertex_t v;
    int sr[5], su[5];
    sr = '{0, -1, 1, 1, -1};
    su = '{0, 1, 1, -1, -1};
    if (p.life == 0) begin
      t = 256;
    end else begin
      quo = (longint'(p.age) << 8) / longint'(p.life);
      t = (quo > 256) ? 256 : quo;
    end
    w = longint'(p.start_width) +
        floor_div_pow2((longint'(p.end_width) - longint'(p.start_width)) * t, 8);
    h = longint'(p.start_height) +
        floor_div_pow2((longint'(p.end_height) - longint'(p.start_height)) * t, 8);
    off[0] = p.offset_x;
    off[1] = p.offset_y;
    off[2] = p.offset_z;
    for (int i = 0; i < 3; i++) begin
      em[i] = $signed(shadow_cfg.emitter_position[20*i +: 20]);
      ctr[i] = sat_coord(off[i] + em[i]);
      rv[i] = floor_div_pow2(longint'($signed(shadow_cfg.right_vector[16*i +: 16])) * w, 14);
      uv[i] = floor_div_pow2(longint'($signed(shadow_cfg.up_vector[16*i +: 16])) * h, 14);
    end
    if (shadow_cfg.mid_point >= 0) begin
      m = shadow_cfg.mid_point;
      if (t < m) begin
        ca = shadow_cfg.start_colors;
        cb = shadow_cfg.mid_colors;
        f = (t * 256) / m;
      end else begin
        ca = shadow_cfg.mid_colors;
        cb = shadow_cfg.end_colors;
        f = ((t - m) * 256) / (256 - m);
      end
    end else begin
      ca = shadow_cfg.start_colors;
      cb = shadow_cfg.end_colors;
      f = t;
    end
    col0 = blend_color(ca[31:0], cb[31:0], f);
    col1 = blend_color(ca[63:32], cb[63:32], f);
    for (int k = 0; k < 5; k++) begin
      v.vertex_index = 3'(k);
      v.vertex_x = sat_coord(ctr[0] + sr[k] * rv[0] + su[k] * uv[0]);
      v.vertex_y = sat_coord(ctr[1] + sr[k] * rv[1] + su[k] * uv[1]);
      v.vertex_z = sat_coord(ctr[2] + sr[k] * rv[2] + su[k] * uv[2]);
      v.color_first = col0;
      v.color_second = col1;
      v.last_vertex = (k == 4);
      expected_vertices.push_back(v);
    end
  endtask

  // Driver: presents the next pending particle and keeps it stable while
  // the block stalls. Idle gaps are only inserted when no word is held.
  // The word on the bus stays at the front of the pending queue until it
  // is accepted.
  always @(posedge clk) begin
    if (rst) begin
      particle_valid <= 1'b0;
    end else if (particle_valid && particle_stall) begin
      // Word is held until accepted.
    end else begin
      if (particle_valid) begin
        predict_quad(particle);
        void'(pending_particles.pop_front());
      end
      if (pending_particles.size() > 0 && !hold_sender &&
          $urandom_range(99) >= send_idle_pct) begin
        particle_valid <= 1'b1;
        particle <= pending_particles[0];
      end else begin
        particle_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted vertex word with the oldest expectation
  // and drives a random stall for the next cycle.
  always @(posedge clk) begin
    vertex_t want;
    if (rst) begin
      vertex_stall <= 1'b0;
    end else begin
      if (vertex_valid && !vertex_stall) begin
        if (expected_vertices.size() == 0) begin
          $error("unexpected vertex word %p", vertex);
          fail_count++;
        end else begin
          want = expected_vertices.pop_front();
          if (vertex.vertex_index !== want.vertex_index) begin
            $error("vertex_index exp %0d got %0d", want.vertex_index, vertex.vertex_index);
            fail_count++;
          end
          if (vertex.vertex_x !== want.vertex_x) begin
            $error("vertex_x exp %0d got %0d", want.vertex_x, vertex.vertex_x);
            fail_count++;
          end
          if (vertex.vertex_y !== want.vertex_y) begin
            $error("vertex_y exp %0d got %0d", want.vertex_y, vertex.vertex_y);
            fail_count++;
          end
          if (vertex.vertex_z !== want.vertex_z) begin
            $error("vertex_z exp %0d got %0d", want.vertex_z, vertex.vertex_z);
            fail_count++;
          end
          if (vertex.color_first !== want.color_first) begin
            $error("color_first exp %h got %h", want.color_first, vertex.color_first);
            fail_count++;
          end
          if (vertex.color_second !== want.color_second) begin
            $error("color_second exp %h got %h", want.color_second, vertex.color_second);
            fail_count++;
          end
          if (vertex.last_vertex !== want.last_vertex) begin
            $error("last_vertex exp %0b got %0b", want.last_vertex, vertex.last_vertex);
            fail_count++;
          end
        end
      end
      vertex_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // APB write: setup cycle then access cycle. Inputs change at clock edges.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START_COLORS:     shadow_cfg.start_colors = value;
      REG_MID_COLORS:       shadow_cfg.mid_colors = value;
      REG_END_COLORS:       shadow_cfg.end_colors = value;
      REG_MID_POINT:        shadow_cfg.mid_point = value[8:0];
      REG_RIGHT_VECTOR:     shadow_cfg.right_vector = value[47:0];
      REG_UP_VECTOR:        shadow_cfg.up_vector = value[47:0];
      REG_EMITTER_POSITION: shadow_cfg.emitter_position = value[59:0];
      default: ;
    endcase
  endtask

  // Waits until every queued particle has been sent and every vertex has
  // arrived, then lets the pipeline drain for its latency.
  task automatic drain();
    while (pending_particles.size() != 0 || particle_valid || expected_vertices.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic particle_t make_particle(logic [15:0] age, logic [15:0] life,
      logic [15:0] sw, logic [15:0] ew, logic [15:0] sh, logic [15:0] eh,
      logic [19:0] ox, logic [19:0] oy, logic [19:0] oz);
    particle_t p;
    p.age = age; p.life = life;
    p.start_width = sw; p.end_width = ew;
    p.start_height = sh; p.end_height = eh;
    p.offset_x = ox; p.offset_y = oy; p.offset_z = oz;
    return p;
  endfunction

  // Random particle. Now and then the life is short, the age lies within it
  // or offset_x is at an extreme, so saturation and clamping get exercised.
  function automatic particle_t random_particle();
    particle_t p;
    p = particle_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: p.life = 16'(1 + $urandom_range(15));
      1: p.age = 16'($urandom_range(p.life));
      2: p.offset_x = $urandom_range(1) ? 20'h7FFFF : 20'h80000;
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [47:0] random_vector();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    // Mostly random components, sometimes raw extremes.
    if ($urandom_range(3) == 0)
      v = {16'h8000, 16'h7FFF, 16'h8000};
    return v;
  endfunction

  task automatic random_settings();
    write_reg(REG_START_COLORS, {$urandom, $urandom});
    write_reg(REG_MID_COLORS, {$urandom, $urandom});
    write_reg(REG_END_COLORS, {$urandom, $urandom});
    case ($urandom_range(3))
      0: write_reg(REG_MID_POINT, 64'h1FF);
      1: write_reg(REG_MID_POINT, 64'(9'h100 + $urandom_range(254)));
      default: write_reg(REG_MID_POINT, 64'($urandom_range(255)));
    endcase
    write_reg(REG_RIGHT_VECTOR, 64'(random_vector()));
    write_reg(REG_UP_VECTOR, 64'(random_vector()));
    write_reg(REG_EMITTER_POSITION, {4'h0, 20'($urandom), 20'($urandom), 20'($urandom)});
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    particle_valid = 1'b0;
    particle = '0;
    vertex_stall = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_sender = 1'b0;
    shadow_cfg.start_colors = COLOR_RESET;
    shadow_cfg.mid_colors = COLOR_RESET;
    shadow_cfg.end_colors = COLOR_RESET;
    shadow_cfg.mid_point = -9'sd1;
    shadow_cfg.right_vector = '0;
    shadow_cfg.up_vector = '0;
    shadow_cfg.emitter_position = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults first: a plain particle with everything at rest.
    pending_particles.push_back(make_particle(16'h0080, 16'h0100, 16'h10, 16'h20,
        16'h10, 16'h20, 20'h0, 20'h0, 20'h0));
    drain();

    // Directed part: extreme colors, full-scale vectors at the emitter corner.
    write_reg(REG_START_COLORS, 64'h0000_0000_FFFF_FFFF);
    write_reg(REG_MID_COLORS, 64'h5A5A_A5A5_0F0F_F0F0);
    write_reg(REG_END_COLORS, 64'hFFFF_FFFF_0000_0000);
    write_reg(REG_MID_POINT, 64'h1FF);
    write_reg(REG_RIGHT_VECTOR, {16'h0, 16'h8000, 16'h7FFF, 16'h4000});
    write_reg(REG_UP_VECTOR, {16'h0, 16'h4000, 16'h8000, 16'h7FFF});
    write_reg(REG_EMITTER_POSITION, {4'h0, 20'h7FFFF, 20'h80000, 20'h00000});
    // Zero life, age beyond life, age zero, age equal to life.
    pending_particles.push_back(make_particle(16'h0100, 16'h0000, 16'hFFFF, 16'h0,
        16'h0, 16'hFFFF, 20'h7FFFF, 20'h80000, 20'h0));
    pending_particles.push_back(make_particle(16'hFFFF, 16'h0001, 16'h0, 16'hFFFF,
        16'hFFFF, 16'h0, 20'h80000, 20'h7FFFF, 20'hFFFFF));
    pending_particles.push_back(make_particle(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 20'h0, 20'h0, 20'h7FFFF));
    pending_particles.push_back(make_particle(16'h1234, 16'h1234, 16'h0, 16'h0,
        16'h0, 16'h0, 20'h80000, 20'h80000, 20'h80000));
    pending_particles.push_back(make_particle(16'h0001, 16'hFFFF, 16'h1000, 16'h0010,
        16'h0010, 16'h1000, 20'h12345, 20'hEDCBA, 20'h00001));
    drain();

    // Mid point at zero, at 255 and at a negative value other than -1.
    write_reg(REG_MID_POINT, 64'h000);
    pending_particles.push_back(make_particle(16'h0040, 16'h0100, 16'h8, 16'h80,
        16'h80, 16'h8, 20'h100, 20'h200, 20'h300));
    pending_particles.push_back(make_particle(16'h0000, 16'h0100, 16'h8, 16'h80,
        16'h80, 16'h8, 20'h100, 20'h200, 20'h300));
    drain();
    write_reg(REG_MID_POINT, 64'h0FF);
    pending_particles.push_back(make_particle(16'h00FE, 16'h0100, 16'h8, 16'h80,
        16'h80, 16'h8, 20'h1, 20'h2, 20'h3));
    pending_particles.push_back(make_particle(16'h0200, 16'h0100, 16'h8, 16'h80,
        16'h80, 16'h8, 20'h1, 20'h2, 20'h3));
    drain();
    write_reg(REG_MID_POINT, 64'h180);
    pending_particles.push_back(make_particle(16'h0080, 16'h0100, 16'h20, 16'h40,
        16'h40, 16'h20, 20'h0, 20'h0, 20'h0));
    drain();
    write_reg(REG_MID_POINT, 64'h080);
    for (int a = 0; a < 4; a++)
      pending_particles.push_back(make_particle(16'(a * 16'h60), 16'h0100, 16'h20, 16'h40,
          16'h40, 16'h20, 20'hFFFF0, 20'h00010, 20'h0));
    drain();

    // Random part in four idling phases, each under fresh settings.
    for (int ph = 0; ph < 4; ph++) begin
      random_settings();
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < 57; n++) begin
        pending_particles.push_back(random_particle());
        // Midway the sender holds off until every vertex has come back.
        if (ph == 2 && n == 28) begin
          while (pending_particles.size() > 1 || particle_valid) @(posedge clk);
          hold_sender = 1'b1;
          while (expected_vertices.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
